// ----- hdl/fbt_pkg.sv -----
// ----------------------------------------------------------------------------
// fbt_pkg
// Shared types and codes for the flash breakpoint table.
// ----------------------------------------------------------------------------
package fbt_pkg;

  typedef enum logic [1:0] {
    ACT_SET   = 2'd0,
    ACT_CLEAR = 2'd1,
    ACT_STEP  = 2'd2,
    ACT_RUN   = 2'd3
  } act_t;

  localparam logic [1:0] KIND_STATUS = 2'd0;
  localparam logic [1:0] KIND_PROG   = 2'd1;
  localparam logic [1:0] KIND_RESUME = 2'd2;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_MISALIGN  = 3'd1;
  localparam logic [2:0] ST_RANGE     = 3'd2;
  localparam logic [2:0] ST_ALREADY   = 3'd3;
  localparam logic [2:0] ST_NO_BP     = 3'd4;
  localparam logic [2:0] ST_NO_PAGE   = 3'd5;
  localparam logic [2:0] ST_NOT_FOUND = 3'd6;

  typedef enum logic [3:0] {
    S_IDLE, S_SCAN, S_SDRAIN, S_DECIDE, S_SETRD, S_SETWR,
    S_CLRRD1, S_CLRRD2, S_CLRWR, S_PCRD, S_PCPATCH, S_RUN, S_RDRAIN, S_FIN
  } st_t;

  typedef struct packed {
    logic        en;
    logic        clr;
    logic [5:0]  idx;
    logic [15:0] addr;
    logic [5:0]  pslot;
    logic [4:0]  off;
  } bp_wr_t;

  typedef struct packed {
    logic        en_tag;
    logic        free;
    logic        en_brk;
    logic        en_dirty;
    logic [5:0]  idx;
    logic [15:0] tag;
    logic [31:0] brk;
    logic [31:0] dirty;
  } pg_wr_t;

  typedef struct packed {
    logic        bp_vld;
    logic [15:0] bp_addr;
    logic [5:0]  bp_pslot;
    logic [4:0]  bp_off;
    logic        pg_vld;
    logic [15:0] pg_tag;
    logic [31:0] brk;
    logic [31:0] dirty;
  } rd_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [2:0]  status;
    logic [5:0]  slot;
    logic [9:0]  page;
    logic [31:0] mask;
    logic        last;
  } res_t;

endpackage

// ----- hdl/flash_breakpoint_table_top.sv -----
// ----------------------------------------------------------------------------
// flash_breakpoint_table_top
// Software breakpoint table for flash patched with c.ebreak halfwords.
// ----------------------------------------------------------------------------
//  channel  | handshake         | fields
//  ---------+-------------------+-----------------------------------------------
//  command  | start / busy      | action, addr
//  result   | done (1 cycle)    | kind, status, slot, page, patch_mask, last
//
//  A command transaction is taken when start is high and busy is low.
//  Every command makes one pass over all BREAK_SLOTS entries through the single
//  table read port (S_SCAN, S_SDRAIN), then the update states. Run adds a second
//  pass over the table (S_RUN, S_RDRAIN) and ends in S_FIN.
//  Results leave as one-cycle pulses on done in the cycle after they are formed;
//  the final one overlaps the first idle cycle. The receiver cannot stall them.
//  Reset (rst, synchronous) empties both tables at once through valid bits.
// ----------------------------------------------------------------------------
module flash_breakpoint_table_top #(
  parameter int BREAK_SLOTS = 64,
  parameter int PAGE_BYTES  = 64,
  parameter int FLASH_BYTES = 16384
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  action,
  input  logic [15:0] addr,
  output logic        done,
  output logic [1:0]  kind,
  output logic [2:0]  status,
  output logic [5:0]  slot,
  output logic [9:0]  page,
  output logic [31:0] patch_mask,
  output logic        last
);
  import fbt_pkg::*;

  localparam int SW   = (BREAK_SLOTS > 1) ? $clog2(BREAK_SLOTS) : 1;
  localparam int OFFB = $clog2(PAGE_BYTES);
  localparam logic [SW-1:0] LAST_IDX = SW'(BREAK_SLOTS - 1);

  st_t state, state_next;

  act_t        act_r;
  logic [15:0] a_r;
  logic [SW-1:0] idx;
  logic        sv, smode;
  logic [SW-1:0] sidx;
  logic        bhit, bfree, phit, pfree;
  logic [5:0]  bidx, bfidx, pidx, pfidx;
  logic [5:0]  b_r, p_r;
  logic        newpg;
  logic [4:0]  off_r;
  logic        pend_vld;
  logic [9:0]  pend_page;
  logic [31:0] pend_mask;

  logic [5:0]  ra;
  bp_wr_t      bpw;
  pg_wr_t      pgw;
  rd_t         rd;
  logic        res_vld;
  res_t        res;
  logic        cmd_push;
  logic [9:0]  cmd_page;
  logic [31:0] cmd_mask;

  logic [15:0] pg_a;
  logic [4:0]  off_a;
  logic [31:0] bit_a;
  logic [2:0]  err_a;
  logic        is_run;

  fbt_store #(.BREAK_SLOTS(BREAK_SLOTS)) u_store (
    .clk(clk), .rst(rst), .ra(ra), .bpw(bpw), .pgw(pgw), .rd(rd)
  );

  // page number and halfword offset of the latched address
  assign pg_a   = 16'(a_r >> OFFB);
  assign off_a  = 5'(a_r[OFFB-1:1]);
  assign bit_a  = 32'd1 << off_a;
  assign is_run = (act_r == ACT_RUN);
  assign err_a  = a_r[0] ? ST_MISALIGN :
                  ((17'(a_r) >= 17'(FLASH_BYTES - 2)) ? ST_RANGE : ST_OK);
  assign busy   = (state != S_IDLE);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:   if (start) state_next = S_SCAN;
      S_SCAN:   if (idx == LAST_IDX) state_next = S_SDRAIN;
      S_SDRAIN: state_next = S_DECIDE;
      S_DECIDE: begin
        unique case (act_r)
          ACT_SET: begin
            if (err_a != ST_OK || bhit || !bfree) state_next = S_IDLE;
            else if (phit)                        state_next = S_SETRD;
            else if (pfree)                       state_next = S_SETWR;
            else                                  state_next = S_IDLE;
          end
          ACT_CLEAR: state_next = (err_a != ST_OK || !bhit) ? S_IDLE : S_CLRRD1;
          default: begin
            if (phit)        state_next = S_PCRD;
            else if (is_run) state_next = S_RUN;
            else             state_next = S_FIN;
          end
        endcase
      end
      S_SETRD:   state_next = S_SETWR;
      S_SETWR:   state_next = S_IDLE;
      S_CLRRD1:  state_next = S_CLRRD2;
      S_CLRRD2:  state_next = S_CLRWR;
      S_CLRWR:   state_next = S_IDLE;
      S_PCRD:    state_next = S_PCPATCH;
      S_PCPATCH: state_next = is_run ? S_RUN : S_FIN;
      S_RUN:     if (idx == LAST_IDX) state_next = S_RDRAIN;
      S_RDRAIN:  state_next = S_FIN;
      S_FIN:     state_next = S_IDLE;
      default:   state_next = S_IDLE;
    endcase
  end

  // table accesses and results
  always_comb begin
    logic [31:0] nd;
    nd       = '0;
    ra       = '0;
    bpw      = '0;
    pgw      = '0;
    res_vld  = 1'b0;
    res      = '0;
    cmd_push = 1'b0;
    cmd_page = '0;
    cmd_mask = '0;

    // sweep stage of run: patch every other occupied page with its full mask, free empty ones
    if (sv && smode && rd.pg_vld && !(phit && 6'(sidx) == pidx)) begin
      pgw.idx = 6'(sidx);
      if (rd.dirty != rd.brk) begin
        cmd_push     = 1'b1;
        cmd_page     = rd.pg_tag[9:0];
        cmd_mask     = rd.brk;
        pgw.en_dirty = 1'b1;
        pgw.dirty    = rd.brk;
      end
      if (rd.brk == '0) pgw.free = 1'b1;
    end

    unique case (state)
      S_SCAN, S_RUN: ra = 6'(idx);
      S_SETRD, S_PCRD: ra = p_r;
      S_CLRRD1: ra = b_r;
      S_CLRRD2: ra = rd.bp_pslot;
      S_DECIDE: begin
        res.kind = KIND_STATUS;
        res.last = 1'b1;
        if (act_r == ACT_SET) begin
          res_vld = 1'b1;
          if (err_a != ST_OK)      res.status = err_a;
          else if (bhit)           res.status = ST_ALREADY;
          else if (!bfree)         res.status = ST_NO_BP;
          else if (!phit && !pfree) res.status = ST_NO_PAGE;
          else                     res_vld = 1'b0;
        end else if (act_r == ACT_CLEAR) begin
          res_vld = 1'b1;
          if (err_a != ST_OK) res.status = err_a;
          else if (!bhit)     res.status = ST_NOT_FOUND;
          else                res_vld = 1'b0;
        end
      end
      S_SETWR: begin
        pgw.idx    = p_r;
        pgw.en_brk = 1'b1;
        pgw.brk    = (newpg ? 32'd0 : rd.brk) | bit_a;
        if (newpg) begin
          pgw.en_tag   = 1'b1;
          pgw.tag      = pg_a;
          pgw.en_dirty = 1'b1;
          pgw.dirty    = '0;
        end
        bpw.en    = 1'b1;
        bpw.idx   = bfidx;
        bpw.addr  = a_r;
        bpw.pslot = p_r;
        bpw.off   = off_a;
        res_vld   = 1'b1;
        res.kind  = KIND_STATUS;
        res.status = ST_OK;
        res.slot  = bfidx;
        res.last  = 1'b1;
      end
      S_CLRWR: begin
        pgw.idx    = p_r;
        pgw.en_brk = 1'b1;
        pgw.brk    = rd.brk & ~(32'd1 << off_r);
        bpw.clr    = 1'b1;
        bpw.idx    = b_r;
        res_vld    = 1'b1;
        res.kind   = KIND_STATUS;
        res.status = ST_OK;
        res.slot   = b_r;
        res.last   = 1'b1;
      end
      S_PCPATCH: begin
        // run: patch all but the pc halfword; step: unpatch only if pc is dirty
        if (is_run || (rd.dirty & bit_a) != '0) begin
          nd = rd.brk & (is_run ? ~bit_a : 32'd0);
          pgw.idx = p_r;
          if (rd.dirty != nd) begin
            cmd_push     = 1'b1;
            cmd_page     = pg_a[9:0];
            cmd_mask     = nd;
            pgw.en_dirty = 1'b1;
            pgw.dirty    = nd;
          end
          if (rd.brk == '0) pgw.free = 1'b1;
        end
      end
      S_FIN: begin
        res_vld  = 1'b1;
        res.last = 1'b1;
        if (pend_vld) begin
          res.kind = KIND_PROG;
          res.page = pend_page;
          res.mask = pend_mask;
        end else begin
          res.kind = KIND_RESUME;
        end
      end
      default: ;
    endcase

    // a new command releases the one held back, which is then not the last
    if (cmd_push && pend_vld) begin
      res_vld  = 1'b1;
      res      = '0;
      res.kind = KIND_PROG;
      res.page = pend_page;
      res.mask = pend_mask;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  // latch the transaction
  always_ff @(posedge clk) begin
    if (start && !busy) begin
      act_r <= act_t'(action);
      a_r   <= addr;
    end
  end

  // sweep counter and read-stage tracking
  always_ff @(posedge clk) begin
    if (rst) begin
      idx   <= '0;
      sv    <= 1'b0;
      smode <= 1'b0;
    end else begin
      idx   <= (state == S_SCAN || state == S_RUN) ? idx + 1'b1 : '0;
      sv    <= (state == S_SCAN || state == S_RUN);
      smode <= (state == S_RUN);
    end
    sidx <= idx;
  end

  // shared compare over the scan: first match and first free in each table
  always_ff @(posedge clk) begin
    if (rst || state == S_IDLE) begin
      bhit  <= 1'b0;
      bfree <= 1'b0;
      phit  <= 1'b0;
      pfree <= 1'b0;
    end else if (sv && !smode) begin
      if (!bhit && rd.bp_vld && rd.bp_addr == a_r) begin
        bhit <= 1'b1;
        bidx <= 6'(sidx);
      end
      if (!bfree && !rd.bp_vld) begin
        bfree <= 1'b1;
        bfidx <= 6'(sidx);
      end
      if (!phit && rd.pg_vld && rd.pg_tag == pg_a) begin
        phit <= 1'b1;
        pidx <= 6'(sidx);
      end
      if (!pfree && !rd.pg_vld) begin
        pfree <= 1'b1;
        pfidx <= 6'(sidx);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DECIDE) begin
      b_r   <= bidx;
      p_r   <= (act_r == ACT_SET && !phit) ? pfidx : pidx;
      newpg <= !phit;
    end
    if (state == S_CLRRD2) begin
      p_r   <= rd.bp_pslot;
      off_r <= rd.bp_off;
    end
  end

  // hold back one program command until it is known whether it is the last
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_vld <= 1'b0;
    end else if (cmd_push) begin
      pend_vld <= 1'b1;
    end else if (state == S_FIN) begin
      pend_vld <= 1'b0;
    end
    if (cmd_push) begin
      pend_page <= cmd_page;
      pend_mask <= cmd_mask;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else     done <= res_vld;
    if (res_vld) begin
      kind       <= res.kind;
      status     <= res.status;
      slot       <= res.slot;
      page       <= res.page;
      patch_mask <= res.mask;
      last       <= res.last;
    end
  end

  a_idle_no_pend: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !pend_vld)
    else $error("program command held while idle");

  a_status_last: assert property (@(posedge clk) disable iff (rst)
    (done && kind == KIND_STATUS) |-> last)
    else $error("status reply not marked last");

  a_resume_only: assert property (@(posedge clk) disable iff (rst)
    (done && kind == KIND_RESUME) |-> (last && patch_mask == '0 && page == '0))
    else $error("resume-only result malformed");

  a_prog_fields: assert property (@(posedge clk) disable iff (rst)
    (done && kind == KIND_PROG) |-> (status == ST_OK && slot == '0))
    else $error("program command carries status or slot");

endmodule

// ----- hdl/fbt_store.sv -----
// ----------------------------------------------------------------------------
// fbt_store
// Breakpoint and page-slot tables: one read address, registered read data.
// ----------------------------------------------------------------------------
module fbt_store #(
  parameter int BREAK_SLOTS = 64
) (
  input  logic            clk,
  input  logic            rst,
  input  logic [5:0]      ra,
  input  fbt_pkg::bp_wr_t bpw,
  input  fbt_pkg::pg_wr_t pgw,
  output fbt_pkg::rd_t    rd
);
  import fbt_pkg::*;

  localparam int SW = (BREAK_SLOTS > 1) ? $clog2(BREAK_SLOTS) : 1;

  logic [15:0] bp_addr_mem  [BREAK_SLOTS];
  logic [5:0]  bp_pslot_mem [BREAK_SLOTS];
  logic [4:0]  bp_off_mem   [BREAK_SLOTS];
  logic [15:0] pg_tag_mem   [BREAK_SLOTS];
  logic [31:0] brk_mem      [BREAK_SLOTS];
  logic [31:0] dirty_mem    [BREAK_SLOTS];
  logic [BREAK_SLOTS-1:0] bp_vld;
  logic [BREAK_SLOTS-1:0] pg_vld;

  // valid bits stand in for the free marks of both tables
  always_ff @(posedge clk) begin
    if (rst) begin
      bp_vld <= '0;
      pg_vld <= '0;
    end else begin
      if (bpw.en)     bp_vld[bpw.idx[SW-1:0]] <= 1'b1;
      if (bpw.clr)    bp_vld[bpw.idx[SW-1:0]] <= 1'b0;
      if (pgw.en_tag) pg_vld[pgw.idx[SW-1:0]] <= 1'b1;
      if (pgw.free)   pg_vld[pgw.idx[SW-1:0]] <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (bpw.en) begin
      bp_addr_mem[bpw.idx[SW-1:0]]  <= bpw.addr;
      bp_pslot_mem[bpw.idx[SW-1:0]] <= bpw.pslot;
      bp_off_mem[bpw.idx[SW-1:0]]   <= bpw.off;
    end
    if (pgw.en_tag)   pg_tag_mem[pgw.idx[SW-1:0]] <= pgw.tag;
    if (pgw.en_brk)   brk_mem[pgw.idx[SW-1:0]]    <= pgw.brk;
    if (pgw.en_dirty) dirty_mem[pgw.idx[SW-1:0]]  <= pgw.dirty;
  end

  always_ff @(posedge clk) begin
    rd.bp_vld   <= bp_vld[ra[SW-1:0]];
    rd.bp_addr  <= bp_addr_mem[ra[SW-1:0]];
    rd.bp_pslot <= bp_pslot_mem[ra[SW-1:0]];
    rd.bp_off   <= bp_off_mem[ra[SW-1:0]];
    rd.pg_vld   <= pg_vld[ra[SW-1:0]];
    rd.pg_tag   <= pg_tag_mem[ra[SW-1:0]];
    rd.brk      <= brk_mem[ra[SW-1:0]];
    rd.dirty    <= dirty_mem[ra[SW-1:0]];
  end

endmodule

// ----- tb/flash_breakpoint_table_top_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// flash_breakpoint_table_top_test
// Drives set, clear, step and run commands into the breakpoint table and
// checks every status, page program and resume reply against a local model.
// ----------------------------------------------------------------------------
module flash_breakpoint_table_top_test;
  import fbt_pkg::*;

  localparam int NSLOT      = 64;
  localparam int PG_BYTES   = 64;
  localparam int FL_BYTES   = 16384;
  localparam logic [15:0] FREE = 16'hFFFF;

  typedef struct packed {
    logic [1:0]  kind;
    logic [2:0]  status;
    logic [5:0]  slot;
    logic [9:0]  page;
    logic [31:0] mask;
    logic        last;
  } reply_t;

  // Breakpoint table model: owns the table copy and the queue of pending replies.
  class bp_table_board;
    logic [15:0] bp_addr [NSLOT];
    logic [5:0]  bp_pslot[NSLOT];
    logic [4:0]  bp_off  [NSLOT];
    logic [15:0] pg_tag  [NSLOT];
    logic [31:0] brk     [NSLOT];
    logic [31:0] dirty   [NSLOT];
    reply_t      pending[$];
    int          errors;

    function new();
      errors = 0;
      for (int i = 0; i < NSLOT; i++) begin
        bp_addr[i] = FREE; pg_tag[i] = FREE;
        bp_pslot[i] = '0; bp_off[i] = '0; brk[i] = '0; dirty[i] = '0;
      end
    endfunction

    function void push(logic [1:0] k, logic [2:0] s, logic [5:0] sl,
                       logic [9:0] pg, logic [31:0] m);
      reply_t r;
      r.kind = k; r.status = s; r.slot = sl; r.page = pg; r.mask = m; r.last = 1'b0;
      pending.push_back(r);
    endfunction

    function void status_reply(logic [2:0] s, logic [5:0] sl);
      push(KIND_STATUS, s, sl, '0, '0);
      pending[$].last = 1'b1;
    endfunction

    function int find_addr(logic [15:0] a);
      for (int i = 0; i < NSLOT; i++) if (bp_addr[i] == a) return i;
      return -1;
    endfunction

    function int find_tag(logic [15:0] t);
      for (int i = 0; i < NSLOT; i++) if (pg_tag[i] == t) return i;
      return -1;
    endfunction

    function void reprogram(int s, logic [31:0] m);
      logic [31:0] nd;
      nd = brk[s] & m;
      if (dirty[s] != nd) begin
        push(KIND_PROG, ST_OK, '0, pg_tag[s][9:0], nd);
        dirty[s] = nd;
      end
      if (brk[s] == '0) pg_tag[s] = FREE;
    endfunction

    function logic [2:0] addr_check(logic [15:0] a);
      if (a[0]) return ST_MISALIGN;
      if (a >= FL_BYTES - 2) return ST_RANGE;
      return ST_OK;
    endfunction

    // Note an accepted command and queue the replies it causes.
    function void note_command(act_t act, logic [15:0] a);
      logic [15:0] pg;
      logic [4:0]  off;
      logic [2:0]  st;
      int b, p, n0;
      pg  = 16'(a / PG_BYTES);
      off = 5'((a % PG_BYTES) / 2);
      n0  = pending.size();
      case (act)
        ACT_SET: begin
          st = addr_check(a);
          if (st != ST_OK) begin status_reply(st, '0); return; end
          if (find_addr(a) >= 0) begin status_reply(ST_ALREADY, '0); return; end
          b = find_addr(FREE);
          if (b < 0) begin status_reply(ST_NO_BP, '0); return; end
          p = find_tag(pg);
          if (p < 0) begin
            p = find_tag(FREE);
            if (p < 0) begin status_reply(ST_NO_PAGE, '0); return; end
            pg_tag[p] = pg; brk[p] = '0; dirty[p] = '0;
          end
          brk[p] |= 32'd1 << off;
          bp_addr[b] = a; bp_pslot[b] = 6'(p); bp_off[b] = off;
          status_reply(ST_OK, 6'(b));
        end
        ACT_CLEAR: begin
          st = addr_check(a);
          if (st != ST_OK) begin status_reply(st, '0); return; end
          b = find_addr(a);
          if (b < 0) begin status_reply(ST_NOT_FOUND, '0); return; end
          brk[bp_pslot[b]] &= ~(32'd1 << bp_off[b]);
          bp_addr[b] = FREE;
          status_reply(ST_OK, 6'(b));
        end
        default: begin
          p = find_tag(pg);
          if (p >= 0 && (act == ACT_RUN || dirty[p][off]))
            reprogram(p, (act == ACT_STEP) ? 32'd0 : ~(32'd1 << off));
          if (act == ACT_RUN)
            for (int i = 0; i < NSLOT; i++)
              if (i != p && pg_tag[i] != FREE) reprogram(i, '1);
          if (pending.size() > n0) pending[$].last = 1'b1;
          else begin
            push(KIND_RESUME, ST_OK, '0, '0, '0);
            pending[$].last = 1'b1;
          end
        end
      endcase
    endfunction

    // Compare one reply against the oldest pending one.
    function void check_reply(reply_t got);
      reply_t w;
      if (pending.size() == 0) begin
        $display("%0t: unexpected reply, expected none, actual %h", $time, got);
        errors++;
        return;
      end
      w = pending.pop_front();
      if (got.kind != w.kind) begin
        $display("%0t: kind expected %0d actual %0d", $time, w.kind, got.kind); errors++;
      end
      if (got.status != w.status) begin
        $display("%0t: status expected %0d actual %0d", $time, w.status, got.status);
        errors++;
      end
      if (got.slot != w.slot) begin
        $display("%0t: slot expected %0d actual %0d", $time, w.slot, got.slot); errors++;
      end
      if (got.page != w.page) begin
        $display("%0t: page expected %0d actual %0d", $time, w.page, got.page); errors++;
      end
      if (got.mask != w.mask) begin
        $display("%0t: patch_mask expected %h actual %h", $time, w.mask, got.mask);
        errors++;
      end
      if (got.last != w.last) begin
        $display("%0t: last expected %0d actual %0d", $time, w.last, got.last); errors++;
      end
    endfunction
  endclass

  logic        clk, rst, start, busy, done, last;
  logic [1:0]  action, kind;
  logic [15:0] addr;
  logic [2:0]  status;
  logic [5:0]  slot;
  logic [9:0]  page;
  logic [31:0] patch_mask;

  bp_table_board board;
  logic [15:0]   hot_addrs[$];  // addresses sent with set commands, to aim clears and resumes

  flash_breakpoint_table_top dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .action(action), .addr(addr),
    .done(done), .kind(kind), .status(status), .slot(slot), .page(page),
    .patch_mask(patch_mask), .last(last)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Sample results at the edge that ends their strobe cycle.
  always @(posedge clk) begin
    if (!rst && done)
      board.check_reply({kind, status, slot, page, patch_mask, last});
  end

  // Hold start up until the transaction is taken, then drop it and wait for a
  // clock edge so the next transaction never drives start in the same time step.
  task automatic send(act_t act, logic [15:0] a);
    start  <= 1'b1;
    action <= act;
    addr   <= a;
    do @(posedge clk); while (busy);
    board.note_command(act, a);
    start <= 1'b0;
    @(posedge clk);
  endtask

  // Idle a random gap: mostly short, now and then long, sometimes none.
  task automatic idle_gap();
    int n;
    n = ($urandom_range(0, 9) < 3) ? 0 :
        ($urandom_range(0, 19) == 0) ? $urandom_range(40, 200) : $urandom_range(1, 4);
    repeat (n) @(posedge clk);
  endtask

  // Pick an address: mostly a few hot pages, sometimes anything at all.
  function automatic logic [15:0] pick_addr();
    int r;
    r = $urandom_range(0, 99);
    if (r < 30 && hot_addrs.size() > 0) return hot_addrs[$urandom_range(0, hot_addrs.size()-1)];
    if (r < 75) return 16'(($urandom_range(0, 7) * PG_BYTES) + 2 * $urandom_range(0, 31));
    if (r < 85) return 16'(2 * $urandom_range(0, FL_BYTES / 2 - 2));
    return 16'($urandom_range(0, 16'hFFFF));
  endfunction

  task automatic drain();
    while (board.pending.size() != 0) @(posedge clk);
  endtask

  initial begin
    act_t        act;
    logic [15:0] a;
    int          r;
    board  = new();
    rst    = 1'b1;
    start  = 1'b0;
    action = ACT_SET;
    addr   = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: field extremes, every action, each address and lookup failure status.
    send(ACT_STEP, 16'h0000);          // resume with nothing set
    send(ACT_RUN, 16'hFFFF);
    send(ACT_SET, 16'h0001);           // misaligned
    send(ACT_SET, 16'hFFFE);           // out of range
    send(ACT_SET, 16'(FL_BYTES - 2));  // boundary of the range check
    send(ACT_SET, 16'(FL_BYTES - 4));
    send(ACT_SET, 16'h0000);
    send(ACT_SET, 16'h0000);           // already set
    send(ACT_SET, 16'h003E);
    send(ACT_CLEAR, 16'h0002);         // not found
    send(ACT_CLEAR, 16'hFFFF);
    send(ACT_CLEAR, 16'hFFFE);
    send(ACT_RUN, 16'h0000);           // patch all but the pc halfword
    send(ACT_STEP, 16'h0000);          // pc halfword not dirty: no reprogram
    send(ACT_STEP, 16'h003E);
    send(ACT_CLEAR, 16'h0000);
    send(ACT_CLEAR, 16'h003E);
    send(ACT_RUN, 16'h1234);           // frees the emptied pages
    drain();                            // sender waits for everything to come back

    // Fill every breakpoint slot on distinct pages: slot and page exhaustion.
    for (int i = 0; i < NSLOT; i++) send(ACT_SET, 16'(i * PG_BYTES + 2 * (i % 32)));
    send(ACT_SET, 16'h1000 + 16'd2);   // no breakpoint slot
    send(ACT_RUN, 16'h0002);
    send(ACT_CLEAR, 16'h0000);
    send(ACT_SET, 16'h2000);           // slot free but every page slot taken
    for (int i = 0; i < NSLOT; i++) send(ACT_CLEAR, 16'(i * PG_BYTES + 2 * (i % 32)));
    send(ACT_RUN, 16'h0000);
    drain();

    // Random: mostly sets, clears and resumes on a few hot pages.
    for (int n = 0; n < 320; n++) begin
      r = $urandom_range(0, 99);
      act = (r < 40) ? ACT_SET : (r < 70) ? ACT_CLEAR : (r < 85) ? ACT_STEP : ACT_RUN;
      a = pick_addr();
      if (act == ACT_SET && hot_addrs.size() < 40) hot_addrs.push_back(a);
      send(act, a);
      if (n == 160) drain();
      idle_gap();
    end

    drain();
    repeat (2 * NSLOT + 20) @(posedge clk);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("FAILURE");
    $finish;
  end

endmodule

// ----- flash_breakpoint_table_top.f -----
hdl/fbt_pkg.sv
hdl/fbt_store.sv
hdl/flash_breakpoint_table_top.sv
tb/flash_breakpoint_table_top_test.sv
